FILE: sv/pixel_bit_packer_with_max_macros.svh
// assertion macros for the pixel bit packer
// used by pixel_bit_packer_with_max.sv; expects clock and reset in the using module
`ifndef PIXEL_BIT_PACKER_WITH_MAX_MACROS_SVH
`define PIXEL_BIT_PACKER_WITH_MAX_MACROS_SVH

// same-cycle implication, checked outside reset
`define PBPACK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PBPACK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pbpack_pkg.sv
// constants and helpers for the pixel bit packer
// no dependencies; used by pixel_bit_packer_with_max
package pbpack_pkg;

   localparam int WORD_BITS    = 32;
   localparam int PIXEL_BITS   = 16;
   localparam int DEPTH_BITS   = 5;
   localparam int BATCH_PIXELS = 32;
   localparam int BATCH_BITS   = $clog2(BATCH_PIXELS);
   localparam int SHIFT_BITS   = $clog2(WORD_BITS);

   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = DEPTH_BITS'(12);
   localparam logic [DEPTH_BITS-1:0] DEPTH_MIN   = DEPTH_BITS'(1);
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX   = DEPTH_BITS'(16);

   // zero counts as one, anything above sixteen as sixteen
   function automatic logic [DEPTH_BITS-1:0] effective_depth(input logic [DEPTH_BITS-1:0] raw);
      logic [DEPTH_BITS-1:0] d;
      if (raw == '0) begin
         d = DEPTH_MIN;
      end else if (raw > DEPTH_MAX) begin
         d = DEPTH_MAX;
      end else begin
         d = raw;
      end
      return d;
   endfunction

endpackage

FILE: sv/pixel_bit_packer_with_max.sv
// pixel bit packer top level: masks pixels to the programmed depth and packs them into words
// depends on pbpack_pkg and pixel_bit_packer_with_max_macros.svh
`include "pixel_bit_packer_with_max_macros.svh"

// Accepts one 16-bit pixel per cycle while the output is free and no flush runs, and packs
// it, masked to bits_per_pixel (0 reads as 1, above 16 as 16), low bits first into 32-bit
// words; batches of 32 pixels give exactly bits_per_pixel words. A pixel goes through an
// input register, one pass of shift/OR logic and the output register. On a pixel marked
// last_pixel that leaves a partial batch, the block completes the batch with the open
// word and then words of zero bits, one word per cycle while the output is free, and
// packs no pixel meanwhile (one more pixel may be taken and held in the input register).
// The final word carries last_word and the largest unmasked pixel of the frame. Writing
// bits_per_pixel drops the partial word and restarts the batch; write it only while the
// block is idle.
module pixel_bit_packer_with_max (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pbpack_pkg::PIXEL_BITS-1:0]   req_pixel,
   input  logic                                req_last_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pbpack_pkg::WORD_BITS-1:0]    rsp_packed_word,
   output logic                                rsp_last_word,
   output logic [pbpack_pkg::PIXEL_BITS-1:0]   rsp_max_pixel,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pbpack_pkg::DEPTH_BITS-1:0]   csr_bits_per_pixel
);

   localparam int WB = pbpack_pkg::WORD_BITS;
   localparam int PB = pbpack_pkg::PIXEL_BITS;
   localparam int DB = pbpack_pkg::DEPTH_BITS;
   localparam int NB = pbpack_pkg::BATCH_BITS;
   localparam int SB = pbpack_pkg::SHIFT_BITS;

   typedef enum logic {ST_RUN, ST_FLUSH} state_type;

   state_type           state_ff,   state_in;
   logic [DB-1:0]       depth_cfg_ff, depth_cfg_in;
   logic                in_valid_ff, in_valid_in;
   logic [PB-1:0]       in_pixel_ff, in_pixel_in;
   logic                in_last_ff,  in_last_in;
   logic [WB-1:0]       acc_ff,     acc_in;
   logic [SB-1:0]       bit_pos_ff, bit_pos_in;
   logic [NB-1:0]       pib_ff,     pib_in;
   logic [DB-1:0]       wd_ff,      wd_in;
   logic [PB-1:0]       max_ff,     max_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WB-1:0]       rsp_word_ff,  rsp_word_in;
   logic                rsp_last_ff,  rsp_last_in;
   logic [PB-1:0]       rsp_max_ff,   rsp_max_in;

   logic                out_free, stage_fire, flush_fire, req_fire, csr_fire;
   logic                flush_done;
   logic [DB-1:0]       depth;
   logic [PB-1:0]       mask, val, max_new;
   logic [WB-1:0]       merged, spill;
   logic [SB:0]         sum, spill_amt;
   logic                word_done, batch_end, flush_final;
   logic [NB-1:0]       pib_next;
   logic [DB-1:0]       wd_after, wd_inc;

   // handshakes
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stage_fire = in_valid_ff && (state_ff == ST_RUN) && out_free;
   assign flush_fire = (state_ff == ST_FLUSH) && out_free;
   assign req_ready  = !in_valid_ff || stage_fire;
   assign req_fire   = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid;
   assign flush_done = flush_fire && flush_final && !csr_fire;

   // packing datapath
   always_comb begin
      depth     = pbpack_pkg::effective_depth(depth_cfg_ff);
      mask      = PB'(((PB+1)'(1) << depth) - (PB+1)'(1));
      val       = in_pixel_ff & mask;
      merged    = acc_ff | (WB'(val) << bit_pos_ff);
      sum       = {1'b0, bit_pos_ff} + (SB+1)'(depth);
      word_done = sum[SB];
      spill_amt = (SB+1)'(WB) - {1'b0, bit_pos_ff};
      spill     = (sum > (SB+1)'(WB)) ? (WB'(val) >> spill_amt) : '0;
      pib_next  = pib_ff + NB'(1);
      batch_end = (pib_next == '0);
      max_new   = (in_pixel_ff > max_ff) ? in_pixel_ff : max_ff;
      wd_inc    = wd_ff + DB'(1);
      wd_after  = word_done ? wd_inc : wd_ff;
      flush_final = (wd_inc == depth);
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      depth_cfg_in = depth_cfg_ff;
      acc_in       = acc_ff;
      bit_pos_in   = bit_pos_ff;
      pib_in       = pib_ff;
      wd_in        = wd_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_max_in   = rsp_max_ff;
      in_valid_in  = in_valid_ff;
      in_pixel_in  = in_pixel_ff;
      in_last_in   = in_last_ff;

      // input register
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_pixel_in = req_pixel;
         in_last_in  = req_last_pixel;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end

      priority if (csr_fire) begin
         // depth change restarts the batch, maximum kept
         depth_cfg_in = csr_bits_per_pixel;
         acc_in       = '0;
         bit_pos_in   = '0;
         pib_in       = '0;
         wd_in        = '0;
      end else if (stage_fire) begin
         // pack one pixel
         max_in     = max_new;
         acc_in     = word_done ? spill : merged;
         bit_pos_in = sum[SB-1:0];
         pib_in     = pib_next;
         wd_in      = batch_end ? '0 : wd_after;
         if (word_done) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = merged;
            rsp_last_in  = in_last_ff && batch_end;
            rsp_max_in   = (in_last_ff && batch_end) ? max_new : '0;
         end
         if (in_last_ff) begin
            if (batch_end) begin
               acc_in     = '0;
               bit_pos_in = '0;
               max_in     = '0;
            end else begin
               state_in = ST_FLUSH;
            end
         end
      end else if (flush_fire) begin
         // pad the open batch one word per cycle while the output is free
         rsp_valid_in = 1'b1;
         rsp_word_in  = acc_ff;
         rsp_last_in  = flush_final;
         rsp_max_in   = flush_final ? max_ff : '0;
         acc_in       = '0;
         wd_in        = wd_inc;
         if (flush_final) begin
            state_in   = ST_RUN;
            bit_pos_in = '0;
            pib_in     = '0;
            wd_in      = '0;
            max_in     = '0;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         depth_cfg_ff <= pbpack_pkg::DEPTH_RESET;
         in_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         bit_pos_ff   <= '0;
         pib_ff       <= '0;
         wd_ff        <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_cfg_ff <= depth_cfg_in;
         in_valid_ff  <= in_valid_in;
         acc_ff       <= acc_in;
         bit_pos_ff   <= bit_pos_in;
         pib_ff       <= pib_in;
         wd_ff        <= wd_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_pixel_ff <= in_pixel_in;
      in_last_ff  <= in_last_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      rsp_max_ff  <= rsp_max_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_word = rsp_word_ff;
   assign rsp_last_word   = rsp_last_ff;
   assign rsp_max_pixel   = rsp_max_ff;

   // checks
   `PBPACK_ASSERT_NOW(a_no_pack_in_flush, state_ff == ST_FLUSH, !stage_fire, "packed in flush")
   `PBPACK_ASSERT_NOW(a_words_below_depth, 1'b1, wd_ff < depth, "word count at depth")
   `PBPACK_ASSERT_NOW(a_batch_start_aligned, pib_ff == '0, bit_pos_ff == '0, "batch misaligned")
   `PBPACK_ASSERT_NOW(a_max_on_last, rsp_valid_ff && !rsp_last_ff, rsp_max_ff == '0, "stray max")
   `PBPACK_ASSERT_NEXT(a_flush_to_run, flush_done, state_ff == ST_RUN, "flush stuck")
   `PBPACK_ASSERT_NEXT(a_flush_clears_max, flush_done, max_ff == '0, "max not cleared")

endmodule

FILE: tb/tb_pixel_bit_packer_with_max.sv
`timescale 1ns / 1ps
// self-checking testbench for pixel_bit_packer_with_max: directed and random pixel frames
// depends on pbpack_pkg and the packer RTL; words are checked against a packing model in this file
module tb_pixel_bit_packer_with_max;

   localparam int PIXEL_BITS   = pbpack_pkg::PIXEL_BITS;
   localparam int WORD_BITS    = pbpack_pkg::WORD_BITS;
   localparam int DEPTH_BITS   = pbpack_pkg::DEPTH_BITS;
   localparam int BATCH_PIXELS = pbpack_pkg::BATCH_PIXELS;
   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = pbpack_pkg::DEPTH_RESET;
   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX   = pbpack_pkg::DEPTH_MAX;

   localparam int MAX_WORDS_PER_PIXEL = 16;
   localparam int PHASE_PIXELS        = 15;
   localparam int DRAIN_CYCLES        = 40;

   typedef struct {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  last;
   } pixel_txn_type;

   typedef struct {
      logic [WORD_BITS-1:0]  word;
      logic                  last;
      logic [PIXEL_BITS-1:0] max_pix;
   } word_txn_type;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_ready;
   logic [PIXEL_BITS-1:0] req_pixel          = '0;
   logic                  req_last_pixel     = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready          = 1'b0;
   logic [WORD_BITS-1:0]  rsp_packed_word;
   logic                  rsp_last_word;
   logic [PIXEL_BITS-1:0] rsp_max_pixel;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [DEPTH_BITS-1:0] csr_bits_per_pixel = '0;

   pixel_txn_type pending_pixels[$];
   word_txn_type  expected_words[$];
   logic        req_taken      = 1'b0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_idle_pct  = 0;
   int unsigned error_count    = 0;

   // packing model state, starts at the reset values
   logic [DEPTH_BITS-1:0] depth_reg      = DEPTH_RESET;
   logic [WORD_BITS-1:0]  fill_word      = '0;
   int unsigned           batch_pos      = 0;
   int unsigned           words_in_batch = 0;
   logic [PIXEL_BITS-1:0] frame_max      = '0;

   pixel_bit_packer_with_max u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel          (req_pixel),
      .req_last_pixel     (req_last_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_packed_word    (rsp_packed_word),
      .rsp_last_word      (rsp_last_word),
      .rsp_max_pixel      (rsp_max_pixel),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_bits_per_pixel (csr_bits_per_pixel)
   );

   always #5 clock = ~clock;

   // pack one accepted pixel and queue the words it completes, plus the pad words at frame end
   function automatic void pack_pixel(input logic [PIXEL_BITS-1:0] pix, input logic last);
      int unsigned          depth;
      int unsigned          shift;
      logic [WORD_BITS-1:0] val;
      word_txn_type         words[$];
      word_txn_type         w;
      depth = (depth_reg == '0) ? 1 : (depth_reg > DEPTH_MAX) ? int'(DEPTH_MAX) : int'(depth_reg);
      val   = WORD_BITS'(pix) & ((32'd1 << depth) - 32'd1);
      shift = (depth * batch_pos) % WORD_BITS;
      if (pix > frame_max) frame_max = pix;
      fill_word |= val << shift;
      // word boundary reached, carry the high part of a split pixel
      if (shift + depth >= WORD_BITS) begin
         w = '{fill_word, 1'b0, 16'h0};
         words.push_back(w);
         fill_word = (shift + depth > WORD_BITS) ? (val >> (WORD_BITS - shift)) : '0;
         words_in_batch++;
      end
      batch_pos = (batch_pos + 1) % BATCH_PIXELS;
      if (batch_pos == 0) words_in_batch = 0;
      // end of frame: pad the open batch, tag the final word
      if (last) begin
         if (batch_pos != 0) begin
            while (words_in_batch < depth && words.size() < MAX_WORDS_PER_PIXEL) begin
               w = '{fill_word, 1'b0, 16'h0};
               words.push_back(w);
               fill_word = '0;
               words_in_batch++;
            end
         end
         if (words.size() > 0) begin
            words[words.size()-1].last    = 1'b1;
            words[words.size()-1].max_pix = frame_max;
         end
         fill_word      = '0;
         batch_pos      = 0;
         words_in_batch = 0;
         frame_max      = '0;
      end
      foreach (words[i]) expected_words.push_back(words[i]);
   endfunction

   function automatic void queue_pixel(input logic [PIXEL_BITS-1:0] pix, input logic last);
      pixel_txn_type t;
      t = '{pix, last};
      pending_pixels.push_back(t);
   endfunction

   // wait until every pixel is sent and every expected word has arrived
   task automatic wait_drained();
      @(posedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
   endtask

   // program the depth while idle; the model restarts its batch but keeps the maximum
   task automatic write_depth(input logic [DEPTH_BITS-1:0] value);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_bits_per_pixel <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      depth_reg      = value;
      fill_word      = '0;
      batch_pos      = 0;
      words_in_batch = 0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // pixel driver
   always @(negedge clock) begin : drive_pixels
      pixel_txn_type t;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               t = pending_pixels.pop_front();
               req_valid      <= 1'b1;
               req_pixel      <= t.pixel;
               req_last_pixel <= t.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor: predict on each pixel transaction, check each word transaction
   always @(posedge clock) begin : check_words
      word_txn_type exp_w;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) pack_pixel(req_pixel, req_last_pixel);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word transaction, packed_word %h", rsp_packed_word);
               error_count++;
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_packed_word !== exp_w.word) begin
                  $error("packed_word: expected %h, actual %h", exp_w.word, rsp_packed_word);
                  error_count++;
               end
               if (rsp_last_word !== exp_w.last) begin
                  $error("last_word: expected %0d, actual %0d", exp_w.last, rsp_last_word);
                  error_count++;
               end
               if (rsp_max_pixel !== exp_w.max_pix) begin
                  $error("max_pixel: expected %h, actual %h", exp_w.max_pix, rsp_max_pixel);
                  error_count++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int unsigned           count;
      int unsigned           len;
      logic                  with_last;
      logic [PIXEL_BITS-1:0] pix;
      logic [DEPTH_BITS-1:0] depth_plan[9];
      depth_plan = '{5'd1, 5'd16, 5'd0, 5'd31, DEPTH_BITS'($urandom_range(17, 30)),
                     DEPTH_BITS'($urandom_range(2, 15)), 5'd12, 5'd3,
                     DEPTH_BITS'($urandom_range(1, 16))};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 13;
      recv_idle_pct = 47;

      // reset depth, extreme pixels
      queue_pixel(16'hFFFF, 1'b0);
      queue_pixel(16'h0000, 1'b0);
      queue_pixel(16'h8001, 1'b0);
      queue_pixel(16'h0FFF, 1'b0);
      queue_pixel(16'h1234, 1'b1);
      // depth zero reads as one
      write_depth(5'd0);
      queue_pixel(16'hFFFF, 1'b0);
      queue_pixel(16'h0001, 1'b0);
      queue_pixel(16'hFFFE, 1'b1);
      // depth above sixteen, frame left open
      write_depth(5'd31);
      queue_pixel(16'hA5A5, 1'b0);
      queue_pixel(16'h5A5A, 1'b0);
      queue_pixel(16'hFFFF, 1'b0);
      // depth change mid frame drops the partial word, keeps the maximum
      write_depth(5'd5);
      queue_pixel(16'h001F, 1'b0);
      queue_pixel(16'h0003, 1'b1);
      // single pixel frame at full depth pads a whole batch
      write_depth(5'd16);
      queue_pixel(16'hFFFF, 1'b1);
      write_depth(5'd17);
      queue_pixel(16'h0000, 1'b0);
      queue_pixel(16'h7FFF, 1'b1);
      write_depth(5'd1);
      queue_pixel(16'h8001, 1'b1);

      // random frames over several depths and idle modes
      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 47;
            recv_idle_pct = 13;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_depth(depth_plan[phase]);
         count = 0;
         while (count < PHASE_PIXELS) begin
            case ($urandom_range(0, 5))
               0: len = BATCH_PIXELS;
               1: len = $urandom_range(33, 40);
               default: len = $urandom_range(1, 20);
            endcase
            // the final frame of a phase is sometimes left open
            with_last = (count + len < PHASE_PIXELS) || ($urandom_range(0, 2) != 0);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 7) == 0) pix = 16'hFFFF;
               else if ($urandom_range(0, 7) == 0) pix = 16'h0000;
               else pix = PIXEL_BITS'($urandom);
               queue_pixel(pix, with_last && (i == len - 1));
            end
            count += len;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
